// File: hw/rtl/asci_pkg.sv
// Shared constants, types and helpers for the ASCII serial integer calculator.
package asci_pkg;

    localparam int MAX_DIGITS_DEF  = 6;
    localparam int RESULT_BITS_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_EQ    = 8'd61;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_MUL   = 8'd42;
    localparam logic [7:0] CH_DIV   = 8'd47;
    localparam logic [7:0] CH_MOD   = 8'd37;
    localparam logic [7:0] CH_POW   = 8'd94;
    localparam logic [7:0] CH_E     = 8'd101;
    localparam logic [7:0] CH_R     = 8'd114;
    localparam logic [7:0] CH_O     = 8'd111;

    localparam logic [2:0] ERR_LEN  = 3'd5;

    typedef struct packed {
        logic       echo;
        logic       finish;
        logic [7:0] ch;
        logic [7:0] op;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    function automatic logic [7:0] err_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = CH_E;
            3'd1:    c = CH_R;
            3'd2:    c = CH_R;
            3'd3:    c = CH_O;
            default: c = CH_R;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/ascii_serial_integer_calculator_unit.sv
// Top level of the ASCII serial integer calculator.
// Input channel: i_valid / o_stall carry one received byte (i_rx_byte) per word.
// Output channel: o_valid / i_stall carry one byte to transmit (o_tx_byte) with
// o_last_of_run set on the final byte caused by an input word.
// Digits and the operator are echoed; the word that ends operand two starts
// evaluation, then '=', the decimal result (or "error") and a newline follow.
// The front end takes a word and queues a command; o_stall rises
// only when the two-entry command queue is full.
// An echo passes through the queue, the back end's command register and the
// output register. Evaluation time is set by the shift-add multiplier (up to
// two products per exponent bit for '^'), the restoring divider (for '/' and
// '%') and the binary to decimal pass (which skips leading zeros, then sends
// each digit).
// A stalled output word holds; the back end waits and the queue then fills.
// Synchronous active-low reset returns both operands, the queue and the
// output register to empty; no words are lost once accepted.
module ascii_serial_integer_calculator_unit #(
    parameter int MAX_DIGITS  = asci_pkg::MAX_DIGITS_DEF,
    parameter int RESULT_BITS = asci_pkg::RESULT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_last_of_run
);
    localparam int OPW = $clog2(10 ** MAX_DIGITS);
    localparam int QW  = asci_pkg::CMD_W + 2 * OPW;

    logic           push, pop, full, empty;
    asci_pkg::t_cmd f_cmd, q_cmd;
    logic [OPW-1:0] f_a, f_b, q_a, q_b;
    logic [QW-1:0]  q_data;

    assign o_stall = full;
    assign q_cmd   = q_data[QW-1 -: asci_pkg::CMD_W];
    assign q_a     = q_data[2*OPW-1 -: OPW];
    assign q_b     = q_data[OPW-1:0];

    asci_front #(.MAX_DIGITS(MAX_DIGITS), .OPW(OPW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_rx_byte(i_rx_byte),
        .i_full   (full),
        .o_push   (push),
        .o_cmd    (f_cmd),
        .o_a      (f_a),
        .o_b      (f_b)
    );

    asci_fifo #(.W(QW), .DEPTH(asci_pkg::QUEUE_DEPTH)) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({f_cmd, f_a, f_b}),
        .i_pop  (pop),
        .o_data (q_data),
        .o_full (full),
        .o_empty(empty)
    );

    asci_back #(.R(RESULT_BITS), .OPW(OPW)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_cmd        (q_cmd),
        .i_a          (q_a),
        .i_b          (q_b),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tx_byte    (o_tx_byte),
        .o_last_of_run(o_last_of_run)
    );
endmodule

// File: hw/rtl/asci_front.sv
// Front end: accepts received bytes, collects operands and queues commands.
module asci_front #(
    parameter int MAX_DIGITS = asci_pkg::MAX_DIGITS_DEF,
    parameter int OPW        = $clog2(10 ** MAX_DIGITS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_full,
    output logic                 o_push,
    output asci_pkg::t_cmd       o_cmd,
    output logic [OPW-1:0]       o_a,
    output logic [OPW-1:0]       o_b
);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    logic           r_phase, n_phase;
    logic [OPW-1:0] r_a, n_a, r_b, n_b;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [7:0]     r_op, n_op;
    logic           is_digit;
    logic [3:0]     dval;
    logic [OPW-1:0] a_next, b_next;

    assign o_push   = i_valid && !i_full;
    assign is_digit = (i_rx_byte >= asci_pkg::CH_ZERO) && (i_rx_byte <= asci_pkg::CH_NINE);
    assign dval     = 4'(i_rx_byte - asci_pkg::CH_ZERO);
    assign a_next   = (r_a << 3) + (r_a << 1) + OPW'(dval);
    assign b_next   = (r_b << 3) + (r_b << 1) + OPW'(dval);

    always_comb begin
        n_phase = r_phase;
        n_a     = r_a;
        n_b     = r_b;
        n_cnt   = r_cnt;
        n_op    = r_op;
        o_cmd   = '{echo: 1'b1, finish: 1'b0, ch: i_rx_byte, op: r_op};
        o_a     = r_a;
        o_b     = r_b;
        if (!r_phase) begin
            if (is_digit && (r_cnt < CW'(MAX_DIGITS))) begin
                n_a   = a_next;
                n_cnt = r_cnt + 1'b1;
            end else begin
                n_op    = i_rx_byte;
                n_phase = 1'b1;
                n_cnt   = '0;
                n_b     = '0;
            end
        end else begin
            if (is_digit) begin
                n_b   = b_next;
                n_cnt = r_cnt + 1'b1;
                o_b   = b_next;
                if (r_cnt + 1'b1 >= CW'(MAX_DIGITS)) begin
                    o_cmd.finish = 1'b1;
                end
            end else begin
                o_cmd.echo   = 1'b0;
                o_cmd.finish = 1'b1;
            end
            if (o_cmd.finish) begin
                n_phase = 1'b0;
                n_a     = '0;
                n_b     = '0;
                n_cnt   = '0;
                n_op    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_a     <= '0;
            r_b     <= '0;
            r_cnt   <= '0;
            r_op    <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_a     <= n_a;
            r_b     <= n_b;
            r_cnt   <= n_cnt;
            r_op    <= n_op;
        end
    end
endmodule

// File: hw/rtl/asci_fifo.sv
// Short command queue between front and back end.
module asci_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = asci_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_n;

    assign o_full  = (r_n == NW'(DEPTH));
    assign o_empty = (r_n == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_n  <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_n <= r_n + NW'(i_push) - NW'(i_pop);
        end
    end
endmodule

// File: hw/rtl/asci_div.sv
// Restoring divider, one quotient bit per cycle.
module asci_div #(
    parameter int W = asci_pkg::RESULT_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_q, r_r, r_d;
    logic [W:0]    sh, diff;

    assign sh     = {r_r, r_q[W-1]};
    assign diff   = sh - {1'b0, r_d};
    assign o_quo  = r_q;
    assign o_rem  = r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_q    <= i_dividend;
                r_r    <= '0;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                if (!diff[W]) begin
                    r_r <= diff[W-1:0];
                end else begin
                    r_r <= sh[W-1:0];
                end
                r_q   <= {r_q[W-2:0], !diff[W]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// File: hw/rtl/asci_back.sv
// Back end: echoes, evaluates the operator and sends the decimal result or "error".
module asci_back #(
    parameter int R   = asci_pkg::RESULT_BITS_DEF,
    parameter int OPW = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  asci_pkg::t_cmd i_cmd,
    input  logic [OPW-1:0] i_a,
    input  logic [OPW-1:0] i_b,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_tx_byte,
    output logic           o_last_of_run
);
    localparam int DIG_MAX = ((R * 1233) >> 12) + 1;
    localparam int IW      = $clog2(DIG_MAX);
    localparam int KW      = $clog2(DIG_MAX + 1);
    localparam int BW      = 4 * DIG_MAX;
    localparam int BCW     = $clog2(R + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ECHO, S_EQ, S_CALC, S_MUL, S_PCHK, S_PSQ, S_PDONE,
        S_DIVW, S_CONV, S_DD, S_SKIP, S_OUTR, S_OUTE, S_ERR, S_NL
    } t_state;

    t_state         r_state, r_ret;
    asci_pkg::t_cmd r_cmd;
    logic [R-1:0]   r_a, r_b, r_val, r_acc, r_base, r_ma, r_mb, r_mp;
    logic           r_dst_acc;
    logic [BW-1:0]  r_bcd, bcd_adj;
    logic [R-1:0]   r_sh;
    logic [BCW-1:0] r_bit;
    logic [3:0]     cur_dig;
    logic [3:0]     r_dq;
    logic [KW-1:0]  r_k;
    logic [2:0]     r_ec;
    logic           r_dstart;
    logic [R-1:0]   r_dnd, r_dsr;
    logic           div_done;
    logic [R-1:0]   div_q, div_r;
    logic           can_emit;
    logic           emit;

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign can_emit = !o_valid || !i_stall;
    assign emit     = can_emit && ((r_state == S_ECHO) || (r_state == S_EQ) ||
                      (r_state == S_OUTE) || (r_state == S_ERR) || (r_state == S_NL));
    assign cur_dig  = r_bcd[{IW'(r_k - 1'b1), 2'b00} +: 4];

    // double-dabble digit adjust
    always_comb begin
        for (int j = 0; j < DIG_MAX; j++) begin
            bcd_adj[4*j +: 4] = (r_bcd[4*j +: 4] >= 4'd5) ? r_bcd[4*j +: 4] + 4'd3
                                                           : r_bcd[4*j +: 4];
        end
    end

    asci_div #(.W(R)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_dstart),
        .i_dividend(r_dnd),
        .i_divisor (r_dsr),
        .o_done    (div_done),
        .o_quo     (div_q),
        .o_rem     (div_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_valid  <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            if (o_valid && !i_stall && !emit) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_cmd;
                        r_a     <= R'(i_a);
                        r_b     <= R'(i_b);
                        r_state <= i_cmd.echo ? S_ECHO : S_EQ;
                    end
                end
                S_ECHO: begin
                    if (can_emit) begin
                        o_valid       <= 1'b1;
                        o_tx_byte     <= r_cmd.ch;
                        o_last_of_run <= !r_cmd.finish;
                        r_state       <= r_cmd.finish ? S_EQ : S_IDLE;
                    end
                end
                S_EQ: begin
                    if (can_emit) begin
                        o_valid       <= 1'b1;
                        o_tx_byte     <= asci_pkg::CH_EQ;
                        o_last_of_run <= 1'b0;
                        r_state       <= S_CALC;
                    end
                end
                S_CALC: begin
                    unique case (r_cmd.op)
                        asci_pkg::CH_PLUS: begin
                            r_val   <= r_a + r_b;
                            r_state <= S_CONV;
                        end
                        asci_pkg::CH_MINUS: begin
                            r_val   <= r_a - r_b;
                            r_state <= S_CONV;
                        end
                        asci_pkg::CH_MUL: begin
                            r_ma      <= r_a;
                            r_mb      <= r_b;
                            r_mp      <= '0;
                            r_dst_acc <= 1'b1;
                            r_ret     <= S_PDONE;
                            r_state   <= S_MUL;
                        end
                        asci_pkg::CH_DIV, asci_pkg::CH_MOD: begin
                            if (r_b == '0) begin
                                r_ec    <= '0;
                                r_state <= S_ERR;
                            end else begin
                                r_dnd    <= r_a;
                                r_dsr    <= r_b;
                                r_dstart <= 1'b1;
                                r_state  <= S_DIVW;
                            end
                        end
                        asci_pkg::CH_POW: begin
                            r_acc   <= R'(1);
                            r_base  <= r_a;
                            r_state <= S_PCHK;
                        end
                        default: begin
                            r_val   <= '0;
                            r_state <= S_CONV;
                        end
                    endcase
                end
                S_MUL: begin
                    if (r_mb == '0) begin
                        if (r_dst_acc) begin
                            r_acc <= r_mp;
                        end else begin
                            r_base <= r_mp;
                        end
                        r_state <= r_ret;
                    end else begin
                        if (r_mb[0]) begin
                            r_mp <= r_mp + r_ma;
                        end
                        r_ma <= r_ma << 1;
                        r_mb <= r_mb >> 1;
                    end
                end
                S_PCHK: begin
                    if (r_b == '0) begin
                        r_state <= S_PDONE;
                    end else if (r_b[0]) begin
                        r_ma      <= r_acc;
                        r_mb      <= r_base;
                        r_mp      <= '0;
                        r_dst_acc <= 1'b1;
                        r_ret     <= S_PSQ;
                        r_state   <= S_MUL;
                    end else begin
                        r_state <= S_PSQ;
                    end
                end
                S_PSQ: begin
                    r_ma      <= r_base;
                    r_mb      <= r_base;
                    r_mp      <= '0;
                    r_dst_acc <= 1'b0;
                    r_b       <= r_b >> 1;
                    r_ret     <= S_PCHK;
                    r_state   <= S_MUL;
                end
                S_PDONE: begin
                    r_val   <= r_acc;
                    r_state <= S_CONV;
                end
                S_DIVW: begin
                    r_dstart <= 1'b0;
                    if (div_done) begin
                        r_val   <= (r_cmd.op == asci_pkg::CH_DIV) ? div_q : div_r;
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_bcd   <= '0;
                    r_sh    <= r_val;
                    r_bit   <= BCW'(R);
                    r_state <= S_DD;
                end
                S_DD: begin
                    r_bcd <= {bcd_adj[BW-2:0], r_sh[R-1]};
                    r_sh  <= r_sh << 1;
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == BCW'(1)) begin
                        r_k     <= KW'(DIG_MAX);
                        r_state <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    if ((r_k > KW'(1)) && (cur_dig == 4'd0)) begin
                        r_k <= r_k - 1'b1;
                    end else begin
                        r_state <= S_OUTR;
                    end
                end
                S_OUTR: begin
                    r_dq    <= cur_dig;
                    r_k     <= r_k - 1'b1;
                    r_state <= S_OUTE;
                end
                S_OUTE: begin
                    if (can_emit) begin
                        o_valid       <= 1'b1;
                        o_tx_byte     <= asci_pkg::CH_ZERO + 8'(r_dq);
                        o_last_of_run <= 1'b0;
                        r_state       <= (r_k == '0) ? S_NL : S_OUTR;
                    end
                end
                S_ERR: begin
                    if (can_emit) begin
                        o_valid       <= 1'b1;
                        o_tx_byte     <= asci_pkg::err_char(r_ec);
                        o_last_of_run <= 1'b0;
                        r_ec          <= r_ec + 1'b1;
                        if (r_ec == asci_pkg::ERR_LEN - 1'b1) begin
                            r_state <= S_NL;
                        end
                    end
                end
                S_NL: begin
                    if (can_emit) begin
                        o_valid       <= 1'b1;
                        o_tx_byte     <= asci_pkg::CH_NL;
                        o_last_of_run <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
